[rtl/mftt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mftt_pkg
// Types and constants shared by the motor feedback turn tracker modules.
// ----------------------------------------------------------------------------
package mftt_pkg;

  localparam logic       FUNC_BASIC = 1'b0;
  localparam logic       FUNC_EXTRA = 1'b1;

  localparam logic [1:0] REG_ANGLE_OFFSET = 2'd0;
  localparam logic [1:0] REG_GEAR_MULTIPLE = 2'd1;
  localparam logic [1:0] REG_SHAFT_SOURCE = 2'd2;

  localparam int unsigned WRAP_JUMP = 4096;
  localparam int unsigned ANGLE_HIGH = 6000;
  localparam int unsigned ANGLE_LOW = 1000;
  localparam int unsigned TURN_SHIFT = 13; // one turn is 8192 counts

  typedef struct packed {
    logic       func;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [7:0] byte6;
  } frame_t;

  typedef struct packed {
    logic [15:0] angle_now;
    logic [15:0] angle_before;
    logic [15:0] speed_held;
    logic [15:0] current_held;
    logic [7:0]  temp_held;
    logic [31:0] counted_turns;
    logic [31:0] absolute_turns;
    logic [15:0] shaft_word;
  } state_t;

  typedef struct packed {
    logic [12:0] angle_offset;
    logic [6:0]  gear_multiple;
    logic        shaft_turn_source;
  } cfg_t;

endpackage

[rtl/motor_feedback_turn_tracker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_feedback_turn_tracker_unit
// Motor feedback frame unpacker with multi-turn encoder tracking.
// ----------------------------------------------------------------------------
// Usage:
//   frame channel (frame_valid/frame_ready) takes one feedback frame per
//   item: func selects a basic frame or an extra output-shaft frame.
//   result channel (result_valid/result_ready) gives one result item per
//   frame, in order, with held fields, position and relative angle.
//   cfg channel writes angle_offset (0), gear_multiple (1) and
//   shaft_turn_source (2); other indexes are dropped. cfg_ready is always
//   high; write only while no frame is in flight.
// Timing:
//   an accepted frame passes through the input register and then the
//   result register, with one pass of logic between them; this gives one
//   item per cycle sustained while the result side does not stall.
// Reset:
//   rst clears all held state and both valid flags, and restores the
//   registers to offset 0, gear multiple 1, counted turns as source.
// Stall:
//   with result_ready low the result register holds; one further frame is
//   taken into the input register, then frame_ready drops.
// ----------------------------------------------------------------------------
module motor_feedback_turn_tracker_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               frame_valid,
  output logic               frame_ready,
  input  logic               func,
  input  logic [7:0]         byte0,
  input  logic [7:0]         byte1,
  input  logic [7:0]         byte2,
  input  logic [7:0]         byte3,
  input  logic [7:0]         byte4,
  input  logic [7:0]         byte5,
  input  logic [7:0]         byte6,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [15:0]        raw_angle,
  output logic signed [15:0] rotor_speed,
  output logic signed [15:0] phase_current,
  output logic [7:0]         temperature,
  output logic signed [31:0] turn_count,
  output logic signed [45:0] position,
  output logic signed [20:0] offset_angle,
  output logic [15:0]        shaft_angle,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data
);

  mftt_pkg::cfg_t   cfg;
  mftt_pkg::frame_t frame_in;
  mftt_pkg::frame_t frame_reg;
  mftt_pkg::state_t held;
  mftt_pkg::state_t held_next;
  logic             frame_full;
  logic             advance;
  logic signed [45:0] position_next;
  logic signed [20:0] relative_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_offset <= '0;
      cfg.gear_multiple <= 7'd1;
      cfg.shaft_turn_source <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mftt_pkg::REG_ANGLE_OFFSET:  cfg.angle_offset <= cfg_data;
        mftt_pkg::REG_GEAR_MULTIPLE: cfg.gear_multiple <= cfg_data[6:0];
        mftt_pkg::REG_SHAFT_SOURCE:  cfg.shaft_turn_source <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  assign advance = frame_full && (!result_valid || result_ready);
  assign frame_ready = !frame_full || advance;

  assign frame_in = '{func: func, byte0: byte0, byte1: byte1, byte2: byte2,
                      byte3: byte3, byte4: byte4, byte5: byte5, byte6: byte6};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_full <= 1'b0;
    end else if (frame_ready) begin
      frame_full <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      frame_reg <= frame_in;
    end
  end

  mftt_state u_state (
    .clk       (clk),
    .rst       (rst),
    .update    (advance),
    .frame     (frame_reg),
    .held      (held),
    .held_next (held_next)
  );

  mftt_calc u_calc (
    .st           (held_next),
    .cfg          (cfg),
    .position     (position_next),
    .offset_angle (relative_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      raw_angle <= held_next.angle_now;
      rotor_speed <= held_next.speed_held;
      phase_current <= held_next.current_held;
      temperature <= held_next.temp_held;
      turn_count <= held_next.counted_turns;
      position <= position_next;
      offset_angle <= relative_next;
      shaft_angle <= held_next.shaft_word;
    end
  end

  // a frame stuck behind a stalled result stays in the input register
  a_frame_held: assert property (@(posedge clk) disable iff (rst)
    frame_full && !advance |=> frame_full)
    else $error("input register lost an item while stalled");

  // held state only moves when an item passes to the result register
  a_state_stable: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(held))
    else $error("held state changed without an item");

  // an extra frame never touches the rotor angle or counted turns
  a_extra_keeps_turns: assert property (@(posedge clk) disable iff (rst)
    advance && frame_reg.func == mftt_pkg::FUNC_EXTRA
    |=> $stable(held.counted_turns) && $stable(held.angle_now))
    else $error("extra frame altered rotor tracking");

  // the counter steps by at most one turn per item
  a_turn_step: assert property (@(posedge clk) disable iff (rst)
    advance |=> (held.counted_turns == $past(held.counted_turns))
      || (held.counted_turns == $past(held.counted_turns) + 32'd1)
      || (held.counted_turns == $past(held.counted_turns) - 32'd1))
    else $error("turn counter jumped by more than one");

  // the reported count is the count just stored
  a_result_matches: assert property (@(posedge clk) disable iff (rst)
    advance |=> turn_count == held.counted_turns)
    else $error("result turn count differs from held count");

endmodule

[rtl/mftt_state.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mftt_state
// Frame unpacking and held feedback state, including the rotor turn counter.
// ----------------------------------------------------------------------------
module mftt_state (
  input  logic             clk,
  input  logic             rst,
  input  logic             update,
  input  mftt_pkg::frame_t frame,
  output mftt_pkg::state_t held,
  output mftt_pkg::state_t held_next
);

  logic [15:0]        new_angle;
  logic signed [17:0] diff;
  logic               big_jump;
  logic               step_down;
  logic               step_up;

  assign new_angle = {frame.byte0, frame.byte1};
  assign diff = $signed({2'b0, new_angle}) - $signed({2'b0, held.angle_now});
  assign big_jump = (diff > $signed(18'(mftt_pkg::WRAP_JUMP)))
                 || (diff < -$signed(18'(mftt_pkg::WRAP_JUMP)));
  // wrap downwards past zero looks like a jump from low to high counts
  assign step_down = big_jump && (new_angle >= 16'(mftt_pkg::ANGLE_HIGH))
                  && (held.angle_now <= 16'(mftt_pkg::ANGLE_LOW));
  assign step_up = big_jump && (new_angle <= 16'(mftt_pkg::ANGLE_LOW))
                && (held.angle_now >= 16'(mftt_pkg::ANGLE_HIGH));

  always_comb begin
    held_next = held;
    if (frame.func == mftt_pkg::FUNC_EXTRA) begin
      held_next.absolute_turns = {frame.byte0, frame.byte1, frame.byte2, frame.byte3};
      held_next.shaft_word = {frame.byte4, frame.byte5};
    end else begin
      held_next.angle_before = held.angle_now;
      held_next.angle_now = new_angle;
      held_next.speed_held = {frame.byte2, frame.byte3};
      held_next.current_held = {frame.byte4, frame.byte5};
      held_next.temp_held = frame.byte6;
      if (step_down) begin
        held_next.counted_turns = held.counted_turns - 32'd1;
      end else if (step_up) begin
        held_next.counted_turns = held.counted_turns + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (update) begin
      held <= held_next;
    end
  end

endmodule

[rtl/mftt_calc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mftt_calc
// Accumulated position and relative angle wrapped into the gear window.
// ----------------------------------------------------------------------------
module mftt_calc (
  input  mftt_pkg::state_t    st,
  input  mftt_pkg::cfg_t      cfg,
  output logic signed [45:0]  position,
  output logic signed [20:0]  offset_angle
);

  logic [31:0]        turns;
  logic signed [21:0] rel;
  logic signed [21:0] half;
  logic signed [21:0] full;
  logic signed [21:0] rel_wrapped;

  assign turns = cfg.shaft_turn_source ? st.absolute_turns : st.counted_turns;
  assign position = $signed({turns[31], turns, 13'd0}) + $signed({30'd0, st.angle_now});

  assign rel = $signed({6'd0, st.angle_now}) - $signed({9'd0, cfg.angle_offset});
  assign half = $signed({3'd0, cfg.gear_multiple, 12'd0});
  assign full = $signed({2'd0, cfg.gear_multiple, 13'd0});

  // one correction at most; a zero gear multiple leaves the difference alone
  always_comb begin
    if (rel > half) begin
      rel_wrapped = rel - full;
    end else if (rel < -half) begin
      rel_wrapped = rel + full;
    end else begin
      rel_wrapped = rel;
    end
  end

  assign offset_angle = rel_wrapped[20:0];

endmodule
